// File: src/tlr_pkg.sv
// Shared types and constants for the thick line rasteriser.
// Used by tlr_front, tlr_queue, tlr_back and thick_line_rasterizer_top.
package tlr_pkg;

  // Fixed field widths
  localparam int RADIUS_W = 6;
  localparam int OFFSET_W = RADIUS_W + 1;
  localparam int FRAME_W  = 13;
  localparam int PIX_W    = 12;
  localparam int COLOR_W  = 32;
  localparam int DEPTH_W  = 16;

  // Frame limits: a pixel coordinate carries 12 bits, so 4096 caps the frame
  localparam logic [FRAME_W-1:0] FRAME_LIMIT   = 13'd4096;
  localparam logic [FRAME_W-1:0] FRAME_W_RESET = 13'd640;
  localparam logic [FRAME_W-1:0] FRAME_H_RESET = 13'd480;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } opcode_t;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_index_t;

  // Decoded command flags carried through the queue
  typedef struct packed {
    opcode_t               op;
    logic [RADIUS_W-1:0]   radius;
    logic                  dir_x_neg;
    logic                  dir_y_neg;
  } tlr_ctrl_t;

  // Queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic valid;
  } tlr_q_status_t;

endpackage

// File: src/tlr_front.sv
// Front end: takes command transactions and decodes them for the back end.
// Works out line deltas, directions, initial error and saturated radius.
// Depends on tlr_pkg.
module tlr_front #(
  parameter int COORD_BITS = 16,
  parameter int MAX_RADIUS = 63
) (
  input  logic                              start,
  input  tlr_pkg::tlr_q_status_t            q_status,
  input  logic                              opcode,
  input  logic signed [COORD_BITS-1:0]      start_x,
  input  logic signed [COORD_BITS-1:0]      start_y,
  input  logic signed [COORD_BITS-1:0]      end_x,
  input  logic signed [COORD_BITS-1:0]      end_y,
  input  logic [tlr_pkg::RADIUS_W-1:0]      brush_radius,
  input  logic [tlr_pkg::COLOR_W-1:0]       color_in,
  input  logic signed [tlr_pkg::DEPTH_W-1:0] depth_in,
  output logic                              push,
  output logic [$bits(tlr_pkg::tlr_ctrl_t) + 7*COORD_BITS + 5 + tlr_pkg::COLOR_W
                + tlr_pkg::DEPTH_W - 1:0] push_data
);
  import tlr_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int EW = COORD_BITS + 3;

  logic signed [DW-1:0] diff_x;
  logic signed [DW-1:0] diff_y;
  logic [DW-1:0]        abs_x;
  logic [DW-1:0]        abs_y;
  logic signed [EW-1:0] err_init;
  logic [RADIUS_W-1:0]  radius_sat;
  tlr_ctrl_t            ctrl;

  // Accept whenever the queue has room
  assign push = start && !q_status.full;

  // Signed deltas and their magnitudes
  assign diff_x = DW'(end_x) - DW'(start_x);
  assign diff_y = DW'(end_y) - DW'(start_y);
  assign abs_x  = diff_x[DW-1] ? DW'(-diff_x) : DW'(diff_x);
  assign abs_y  = diff_y[DW-1] ? DW'(-diff_y) : DW'(diff_y);

  // Initial error term dx - dy
  assign err_init = EW'(abs_x) - EW'(abs_y);

  // Radius clamp
  always_comb begin
    if (int'(brush_radius) > MAX_RADIUS) begin
      radius_sat = RADIUS_W'(MAX_RADIUS);
    end else begin
      radius_sat = brush_radius;
    end
  end

  assign ctrl.op        = opcode_t'(opcode);
  assign ctrl.radius    = radius_sat;
  assign ctrl.dir_x_neg = diff_x[DW-1];
  assign ctrl.dir_y_neg = diff_y[DW-1];

  assign push_data = {ctrl, start_x, start_y, end_x, end_y, abs_x, abs_y, err_init,
                      color_in, depth_in};

endmodule

// File: src/tlr_queue.sv
// Short register queue between the front and back ends.
// Generic width and depth; status travels as tlr_pkg::tlr_q_status_t.
// Depends on tlr_pkg.
module tlr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [WIDTH-1:0]       push_data,
  input  logic                   pop,
  output tlr_pkg::tlr_q_status_t status,
  output logic [WIDTH-1:0]       head_data
);
  import tlr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.valid = (count != '0);
  assign head_data    = store[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && status.full && !pop))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> status.valid)
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

// File: src/tlr_back.sv
// Back end: Bresenham walk with a disc brush, one brush offset per tick.
// Holds the frame size registers and drives the registered pixel outputs.
// Depends on tlr_pkg.
module tlr_back #(
  parameter int COORD_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_valid,
  input  logic [$bits(tlr_pkg::tlr_ctrl_t) + 7*COORD_BITS + 5 + tlr_pkg::COLOR_W
                + tlr_pkg::DEPTH_W - 1:0]    head_data,
  output logic                               pop,
  input  logic                               cfg_valid,
  input  logic                               cfg_index,
  input  logic [tlr_pkg::FRAME_W-1:0]        cfg_data,
  output logic                               pixel_valid,
  output logic [tlr_pkg::PIX_W-1:0]          pixel_x,
  output logic [tlr_pkg::PIX_W-1:0]          pixel_y,
  output logic [tlr_pkg::COLOR_W-1:0]        color_out,
  output logic signed [tlr_pkg::DEPTH_W-1:0] depth_out,
  output logic                               write_enable,
  output logic                               last_pixel
);
  import tlr_pkg::*;

  localparam int DW   = COORD_BITS + 1;
  localparam int EW   = COORD_BITS + 3;
  localparam int NW   = COORD_BITS + 2;
  localparam int CMPW = (NW > FRAME_W + 1) ? NW : FRAME_W + 1;
  localparam int SQW  = 2 * OFFSET_W;

  // Head entry fields
  tlr_ctrl_t                   h_ctrl;
  logic signed [COORD_BITS-1:0] h_sx, h_sy, h_ex, h_ey;
  logic [DW-1:0]               h_dx, h_dy;
  logic signed [EW-1:0]        h_err;
  logic [COLOR_W-1:0]          h_color;
  logic signed [DEPTH_W-1:0]   h_depth;

  assign {h_ctrl, h_sx, h_sy, h_ex, h_ey, h_dx, h_dy, h_err, h_color, h_depth} = head_data;

  // Line state
  logic                         active;
  logic signed [COORD_BITS-1:0] cur_x, cur_y, tgt_x, tgt_y;
  logic [DW-1:0]                delta_x, delta_y;
  logic                         dir_x_neg, dir_y_neg;
  logic signed [EW-1:0]         err;
  logic [RADIUS_W-1:0]          radius;
  logic signed [OFFSET_W-1:0]   off_i, off_j;
  logic [COLOR_W-1:0]           line_color;
  logic signed [DEPTH_W-1:0]    line_depth;
  logic [FRAME_W-1:0]           frame_w, frame_h;

  logic do_load, do_tick;

  // The back end never stalls: drain one entry per cycle
  assign pop     = q_valid;
  assign do_load = pop && (h_ctrl.op == OP_LOAD) && !active;
  assign do_tick = pop && (h_ctrl.op == OP_TICK) && active;

  // Pixel position and frame test
  logic signed [NW-1:0]   nx, ny;
  logic signed [CMPW-1:0] nx_c, ny_c, lim_x, lim_y;
  logic [FRAME_W-1:0]     w_lim, h_lim;
  logic                   in_frame;

  assign nx    = NW'(cur_x) + NW'(off_i);
  assign ny    = NW'(cur_y) + NW'(off_j);
  assign nx_c  = CMPW'(nx);
  assign ny_c  = CMPW'(ny);
  assign w_lim = (frame_w > FRAME_LIMIT) ? FRAME_LIMIT : frame_w;
  assign h_lim = (frame_h > FRAME_LIMIT) ? FRAME_LIMIT : frame_h;
  assign lim_x = CMPW'(w_lim);
  assign lim_y = CMPW'(h_lim);
  assign in_frame = !nx_c[CMPW-1] && (nx_c < lim_x) && !ny_c[CMPW-1] && (ny_c < lim_y);

  // Disc test: i*i + j*j <= r*r
  logic signed [SQW-1:0] i_w, j_w;
  logic [SQW-1:0]        r_w, sq_i, sq_j, sq_r;
  logic [SQW:0]          disc_sum;
  logic                  in_disc, we;

  assign i_w      = SQW'(off_i);
  assign j_w      = SQW'(off_j);
  assign r_w      = SQW'(radius);
  assign sq_i     = i_w * i_w;
  assign sq_j     = j_w * j_w;
  assign sq_r     = r_w * r_w;
  assign disc_sum = (SQW + 1)'(sq_i) + (SQW + 1)'(sq_j);
  assign in_disc  = disc_sum <= (SQW + 1)'(sq_r);
  assign we       = in_disc && in_frame;

  // Offset scan position
  logic signed [OFFSET_W-1:0] r_pos, r_neg;
  logic                       j_end, i_end, at_target;

  assign r_pos     = OFFSET_W'(radius);
  assign r_neg     = -r_pos;
  assign j_end     = (off_j == r_pos);
  assign i_end     = (off_i == r_pos);
  assign at_target = (cur_x == tgt_x) && (cur_y == tgt_y);

  // Bresenham step
  logic signed [EW:0]           e2, dx_e, dy_e;
  logic                         step_x, step_y;
  logic signed [EW-1:0]         err_next;
  logic signed [COORD_BITS-1:0] cur_x_next, cur_y_next;

  assign e2     = {err, 1'b0};
  assign dx_e   = (EW + 1)'(delta_x);
  assign dy_e   = (EW + 1)'(delta_y);
  assign step_x = e2 > -dy_e;
  assign step_y = e2 < dx_e;

  always_comb begin
    err_next   = err;
    cur_x_next = cur_x;
    cur_y_next = cur_y;
    if (step_x) begin
      err_next   = err_next - EW'(delta_y);
      cur_x_next = dir_x_neg ? cur_x - 1'b1 : cur_x + 1'b1;
    end
    if (step_y) begin
      err_next   = err_next + EW'(delta_x);
      cur_y_next = dir_y_neg ? cur_y - 1'b1 : cur_y + 1'b1;
    end
  end

  // Control state, configuration registers and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      pixel_valid  <= 1'b0;
      write_enable <= 1'b0;
      last_pixel   <= 1'b0;
      frame_w      <= FRAME_W_RESET;
      frame_h      <= FRAME_H_RESET;
    end else begin
      if (cfg_valid) begin
        case (reg_index_t'(cfg_index))
          REG_FRAME_WIDTH:  frame_w <= cfg_data;
          REG_FRAME_HEIGHT: frame_h <= cfg_data;
          default: ;
        endcase
      end
      pixel_valid  <= do_tick;
      write_enable <= do_tick && we;
      last_pixel   <= do_tick && j_end && i_end && at_target;
      if (do_load) begin
        active <= 1'b1;
      end else if (do_tick && j_end && i_end && at_target) begin
        active <= 1'b0;
      end
    end
  end

  // Line payload and pixel outputs
  always_ff @(posedge clk) begin
    if (do_load) begin
      cur_x      <= h_sx;
      cur_y      <= h_sy;
      tgt_x      <= h_ex;
      tgt_y      <= h_ey;
      delta_x    <= h_dx;
      delta_y    <= h_dy;
      dir_x_neg  <= h_ctrl.dir_x_neg;
      dir_y_neg  <= h_ctrl.dir_y_neg;
      err        <= h_err;
      radius     <= h_ctrl.radius;
      off_i      <= -OFFSET_W'(h_ctrl.radius);
      off_j      <= -OFFSET_W'(h_ctrl.radius);
      line_color <= h_color;
      line_depth <= h_depth;
    end else if (do_tick) begin
      if (j_end) begin
        off_j <= r_neg;
        if (i_end) begin
          off_i <= r_neg;
          if (!at_target) begin
            err   <= err_next;
            cur_x <= cur_x_next;
            cur_y <= cur_y_next;
          end
        end else begin
          off_i <= off_i + 1'b1;
        end
      end else begin
        off_j <= off_j + 1'b1;
      end
    end
    if (do_tick) begin
      pixel_x   <= we ? nx_c[PIX_W-1:0] : '0;
      pixel_y   <= we ? ny_c[PIX_W-1:0] : '0;
      color_out <= line_color;
      depth_out <= line_depth;
    end
  end

`ifndef SYNTHESIS
  a_result_from_tick: assert property (@(posedge clk) disable iff (rst)
    pixel_valid |-> $past(do_tick))
    else $error("result strobe without an active tick");
  a_last_goes_idle: assert property (@(posedge clk) disable iff (rst)
    last_pixel |-> (pixel_valid && !active))
    else $error("final pixel without return to idle");
  a_masked_position: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid && !write_enable) |-> (pixel_x == '0 && pixel_y == '0))
    else $error("position not cleared on a masked offset");
`endif

endmodule

// File: src/thick_line_rasterizer_top.sv
// Thick line rasteriser: Bresenham line walk stamping a disc brush.
// Result path: a tick transaction's pixel result is held in the queue register and
// then in the output register after acceptance.
// Throughput: one transaction per cycle; the back end pops the queue every cycle
// and the receiver cannot stall, so the queue never fills and busy stays low.
// Reset (rst, synchronous): block idle, queue empty, frame size 640 x 480.
module thick_line_rasterizer_top #(
  parameter int COORD_BITS = 16,
  parameter int MAX_RADIUS = 63
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               opcode,
  input  logic signed [COORD_BITS-1:0]       start_x,
  input  logic signed [COORD_BITS-1:0]       start_y,
  input  logic signed [COORD_BITS-1:0]       end_x,
  input  logic signed [COORD_BITS-1:0]       end_y,
  input  logic [tlr_pkg::RADIUS_W-1:0]       brush_radius,
  input  logic [tlr_pkg::COLOR_W-1:0]        color_in,
  input  logic signed [tlr_pkg::DEPTH_W-1:0] depth_in,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_index,
  input  logic [tlr_pkg::FRAME_W-1:0]        cfg_data,
  output logic                               pixel_valid,
  output logic [tlr_pkg::PIX_W-1:0]          pixel_x,
  output logic [tlr_pkg::PIX_W-1:0]          pixel_y,
  output logic [tlr_pkg::COLOR_W-1:0]        color_out,
  output logic signed [tlr_pkg::DEPTH_W-1:0] depth_out,
  output logic                               write_enable,
  output logic                               last_pixel
);
  import tlr_pkg::*;

  localparam int QW = $bits(tlr_ctrl_t) + 7*COORD_BITS + 5 + COLOR_W + DEPTH_W;

  tlr_q_status_t   q_status;
  logic            push;
  logic            pop;
  logic [QW-1:0]   push_data;
  logic [QW-1:0]   head_data;

  // Registers are always writable
  assign cfg_ready = 1'b1;
  assign busy      = q_status.full;

  tlr_front #(
    .COORD_BITS (COORD_BITS),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_front (
    .start        (start),
    .q_status     (q_status),
    .opcode       (opcode),
    .start_x      (start_x),
    .start_y      (start_y),
    .end_x        (end_x),
    .end_y        (end_y),
    .brush_radius (brush_radius),
    .color_in     (color_in),
    .depth_in     (depth_in),
    .push         (push),
    .push_data    (push_data)
  );

  tlr_queue #(
    .WIDTH (QW),
    .DEPTH (2)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .status    (q_status),
    .head_data (head_data)
  );

  tlr_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_status.valid),
    .head_data    (head_data),
    .pop          (pop),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .color_out    (color_out),
    .depth_out    (depth_out),
    .write_enable (write_enable),
    .last_pixel   (last_pixel)
  );

endmodule

// File: tb/sv/tb_thick_line_rasterizer_top.sv
// Self-checking testbench for thick_line_rasterizer_top: directed and random line commands.
// Needs tlr_pkg and the rasteriser RTL; a scoreboard class predicts every pixel result.
module tb_thick_line_rasterizer_top;
  import tlr_pkg::*;

  localparam int COORD_W     = 16;
  localparam int MAX_R       = 63;
  localparam int SETTLE      = 8;     // cycles past the last result before config or end
  localparam int QUIET_LIMIT = 2000;  // watchdog: cycles with no transaction of any kind
  localparam int PHASE_ITEMS = 50;

  // One pixel result as seen on the output ports
  typedef struct packed {
    logic [PIX_W-1:0]   px;
    logic [PIX_W-1:0]   py;
    logic [COLOR_W-1:0] colour;
    logic [DEPTH_W-1:0] depth;
    logic               we;
    logic               last;
  } pixel_rec_t;

  // Line walker and brush stamper, with the queue of pixels still to arrive
  class brush_stamp_model;
    logic [FRAME_W-1:0]        frame_w, frame_h;
    logic signed [COORD_W-1:0] cur_x, cur_y, tgt_x, tgt_y;
    logic [COORD_W:0]          span_x, span_y;
    logic                      step_x_neg, step_y_neg;
    logic signed [COORD_W+2:0] err_acc;
    logic [RADIUS_W-1:0]       radius;
    logic signed [OFFSET_W-1:0] off_i, off_j;
    logic [COLOR_W-1:0]        colour;
    logic [DEPTH_W-1:0]        depth;
    bit                        drawing;
    pixel_rec_t                pending_pixels[$];
    int                        errors;

    function new();
      frame_w = FRAME_W_RESET;
      frame_h = FRAME_H_RESET;
      cur_x = '0; cur_y = '0; tgt_x = '0; tgt_y = '0;
      span_x = '0; span_y = '0;
      step_x_neg = 1'b0; step_y_neg = 1'b0;
      err_acc = '0; radius = '0; off_i = '0; off_j = '0;
      colour = '0; depth = '0;
      drawing = 1'b0;
      errors = 0;
    endfunction

    function void set_frame(reg_index_t idx, logic [FRAME_W-1:0] val);
      if (idx == REG_FRAME_WIDTH) frame_w = val;
      else frame_h = val;
    endfunction

    // Pixel coordinates are 12 bits, so larger frames behave as 4096
    function int frame_lim(logic [FRAME_W-1:0] v);
      return (v > FRAME_LIMIT) ? int'(FRAME_LIMIT) : int'(v);
    endfunction

    // Apply one accepted command transaction; returns 1 if it was not ignored
    function bit note_command(opcode_t op, logic signed [COORD_W-1:0] sx,
                              logic signed [COORD_W-1:0] sy, logic signed [COORD_W-1:0] ex,
                              logic signed [COORD_W-1:0] ey, logic [RADIUS_W-1:0] r,
                              logic [COLOR_W-1:0] c, logic [DEPTH_W-1:0] d);
      int         nx, ny, ni, nj, e2, rr;
      bit         in_disc, in_frame, we;
      pixel_rec_t rec;
      if (op == OP_LOAD) begin
        if (drawing) return 1'b0;
        cur_x = sx; cur_y = sy; tgt_x = ex; tgt_y = ey;
        span_x = (ex >= sx) ? (COORD_W + 1)'(int'(ex) - int'(sx))
                            : (COORD_W + 1)'(int'(sx) - int'(ex));
        span_y = (ey >= sy) ? (COORD_W + 1)'(int'(ey) - int'(sy))
                            : (COORD_W + 1)'(int'(sy) - int'(ey));
        step_x_neg = ex < sx;
        step_y_neg = ey < sy;
        err_acc = (COORD_W + 3)'(int'(span_x) - int'(span_y));
        rr = (int'(r) > MAX_R) ? MAX_R : int'(r);
        radius = RADIUS_W'(rr);
        off_i = OFFSET_W'(-rr);
        off_j = OFFSET_W'(-rr);
        colour = c;
        depth = d;
        drawing = 1'b1;
        return 1'b1;
      end
      if (!drawing) return 1'b0;

      // Test the current brush offset
      rr = int'(radius);
      nx = int'(cur_x) + int'(off_i);
      ny = int'(cur_y) + int'(off_j);
      in_disc = int'(off_i) * int'(off_i) + int'(off_j) * int'(off_j) <= rr * rr;
      in_frame = nx >= 0 && nx < frame_lim(frame_w) && ny >= 0 && ny < frame_lim(frame_h);
      we = in_disc && in_frame;
      rec.px = we ? nx[PIX_W-1:0] : '0;
      rec.py = we ? ny[PIX_W-1:0] : '0;
      rec.colour = colour;
      rec.depth = depth;
      rec.we = we;
      rec.last = 1'b0;

      // Advance the offset scan, then the line walk after the final offset
      nj = int'(off_j) + 1;
      if (nj > rr) begin
        off_j = OFFSET_W'(-rr);
        ni = int'(off_i) + 1;
        if (ni > rr) begin
          off_i = OFFSET_W'(-rr);
          if (cur_x == tgt_x && cur_y == tgt_y) begin
            rec.last = 1'b1;
            drawing = 1'b0;
          end else begin
            e2 = 2 * int'(err_acc);
            if (e2 > -int'(span_y)) begin
              err_acc = (COORD_W + 3)'(int'(err_acc) - int'(span_y));
              cur_x = COORD_W'(int'(cur_x) + (step_x_neg ? -1 : 1));
            end
            if (e2 < int'(span_x)) begin
              err_acc = (COORD_W + 3)'(int'(err_acc) + int'(span_x));
              cur_y = COORD_W'(int'(cur_y) + (step_y_neg ? -1 : 1));
            end
          end
        end else begin
          off_i = OFFSET_W'(ni);
        end
      end else begin
        off_j = OFFSET_W'(nj);
      end
      pending_pixels.push_back(rec);
      return 1'b1;
    endfunction

    // Compare one pixel result with the oldest prediction
    function void check_pixel(pixel_rec_t got);
      pixel_rec_t want;
      if (pending_pixels.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected pixel result: x %0d y %0d we %0b last %0b",
                   got.px, got.py, got.we, got.last);
        return;
      end
      want = pending_pixels.pop_front();
      if (got.px !== want.px || got.py !== want.py || got.colour !== want.colour ||
          got.depth !== want.depth || got.we !== want.we || got.last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display({"pixel mismatch (exp/act): x %0d/%0d y %0d/%0d colour %h/%h ",
                    "depth %h/%h we %0b/%0b last %0b/%0b"},
                   want.px, got.px, want.py, got.py, want.colour, got.colour,
                   want.depth, got.depth, want.we, got.we, want.last, got.last);
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic                      opcode;
  logic signed [COORD_W-1:0] start_x, start_y, end_x, end_y;
  logic [RADIUS_W-1:0]       brush_radius;
  logic [COLOR_W-1:0]        color_in;
  logic signed [DEPTH_W-1:0] depth_in;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic                      cfg_index;
  logic [FRAME_W-1:0]        cfg_data;
  logic                      pixel_valid;
  logic [PIX_W-1:0]          pixel_x, pixel_y;
  logic [COLOR_W-1:0]        color_out;
  logic signed [DEPTH_W-1:0] depth_out;
  logic                      write_enable;
  logic                      last_pixel;

  brush_stamp_model sb;
  int               items_sent;
  int               gap_top;
  int               quiet_cycles;

  thick_line_rasterizer_top #(
    .COORD_BITS(COORD_W),
    .MAX_RADIUS(MAX_R)
  ) u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
    .brush_radius(brush_radius), .color_in(color_in), .depth_in(depth_in),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .pixel_valid(pixel_valid), .pixel_x(pixel_x),
    .pixel_y(pixel_y), .color_out(color_out), .depth_out(depth_out),
    .write_enable(write_enable), .last_pixel(last_pixel)
  );

  // Clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result monitor and watchdog
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (pixel_valid)
        sb.check_pixel('{pixel_x, pixel_y, color_out, depth_out, write_enable, last_pixel});
      if ((start && !busy) || (cfg_valid && cfg_ready) || pixel_valid) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Drive one command transaction and wait for it to be taken
  task automatic send_item(opcode_t op, logic signed [COORD_W-1:0] sx,
                           logic signed [COORD_W-1:0] sy, logic signed [COORD_W-1:0] ex,
                           logic signed [COORD_W-1:0] ey, logic [RADIUS_W-1:0] r,
                           logic [COLOR_W-1:0] c, logic [DEPTH_W-1:0] d);
    int gap;
    gap = $urandom_range(0, gap_top);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    opcode <= op;
    start_x <= sx; start_y <= sy; end_x <= ex; end_y <= ey;
    brush_radius <= r;
    color_in <= c;
    depth_in <= d;
    do @(posedge clk); while (busy);
    if (sb.note_command(op, sx, sy, ex, ey, r, c, d)) items_sent++;
  endtask

  // Tick with junk in the unused fields
  task automatic send_tick();
    send_item(OP_TICK, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
              COORD_W'($urandom), RADIUS_W'($urandom), $urandom, DEPTH_W'($urandom));
  endtask

  // Sender holds off until every predicted pixel has come out
  task automatic wait_drained(int extra);
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Load a line, then tick until its end point is fully stamped
  task automatic draw_line(logic signed [COORD_W-1:0] sx, logic signed [COORD_W-1:0] sy,
                           logic signed [COORD_W-1:0] ex, logic signed [COORD_W-1:0] ey,
                           logic [RADIUS_W-1:0] r, logic [COLOR_W-1:0] c,
                           logic [DEPTH_W-1:0] d, int noise_pct);
    send_item(OP_LOAD, sx, sy, ex, ey, r, c, d);
    while (sb.drawing) begin
      // loads while drawing must be ignored
      if ($urandom_range(0, 99) < noise_pct)
        send_item(OP_LOAD, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                  COORD_W'($urandom), RADIUS_W'($urandom), $urandom, DEPTH_W'($urandom));
      if ($urandom_range(0, 199) == 0) wait_drained(0);
      send_tick();
    end
  endtask

  task automatic write_reg(reg_index_t idx, logic [FRAME_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_frame(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [COORD_W-1:0] pick_coord(int lim);
    int v;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 6) v = int'($urandom_range(0, lim + 6)) - 3;
    else if (mode < 8) v = lim - 3 + int'($urandom_range(0, 5));
    else v = int'($urandom);
    return v[COORD_W-1:0];
  endfunction

  // End point a few pixels from the start, kept inside the coordinate range
  function automatic logic signed [COORD_W-1:0] near(logic signed [COORD_W-1:0] base,
                                                     int span);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * span)) - span;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[COORD_W-1:0];
  endfunction

  // Mostly small brushes and short lines; a few wider brushes on near-points
  task automatic random_line();
    int                  rsel, span;
    logic [RADIUS_W-1:0] r;
    logic signed [COORD_W-1:0] sx, sy;
    gap_top = ($urandom_range(0, 9) < 3) ? 0 : 3;
    rsel = $urandom_range(0, 99);
    if (rsel < 55) begin
      r = RADIUS_W'($urandom_range(0, 2)); span = 4;
    end else if (rsel < 95) begin
      r = RADIUS_W'($urandom_range(3, 5)); span = 3;
    end else begin
      r = RADIUS_W'($urandom_range(6, 9)); span = 1;
    end
    sx = pick_coord(sb.frame_lim(sb.frame_w));
    sy = pick_coord(sb.frame_lim(sb.frame_h));
    draw_line(sx, sy, near(sx, span), near(sy, span), r, $urandom, DEPTH_W'($urandom), 5);
    // stray ticks between lines are ignored
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 2)) send_tick();
  endtask

  // Stimulus
  initial begin
    logic [FRAME_W-1:0] phase_w[7];
    logic [FRAME_W-1:0] phase_h[7];
    rst = 1'b1;
    start = 1'b0;
    opcode = OP_LOAD;
    start_x = '0; start_y = '0; end_x = '0; end_y = '0;
    brush_radius = '0;
    color_in = '0;
    depth_in = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data = '0;
    items_sent = 0;
    gap_top = 3;
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset frame size of 640 x 480
    send_tick();                                                  // tick while idle
    draw_line(0, 0, 0, 0, 0, 32'h0000_0000, 16'h0000, 0);          // single point
    draw_line(0, 0, 3, 1, 1, 32'hFFFF_FFFF, 16'h7FFF, 30);         // loads while busy
    draw_line(639, 479, 636, 477, 2, 32'hA5A5_5A5A, 16'h8000, 0);  // frame corner, both negative
    draw_line(-32768, -32768, -32766, -32765, 1, 32'h1234_5678, 16'hFFFF, 0);
    draw_line(32767, 32767, 32765, 32767, 1, 32'h8000_0001, 16'h0001, 0);  // horizontal
    draw_line(10, 5, 10, 9, 0, 32'h0F0F_0F0F, 16'h1234, 0);        // vertical
    draw_line(5, 2, 2, 9, 1, 32'h7FFF_FFFE, 16'hC000, 0);          // steep, x falling
    draw_line(-2, -1, 1, 2, 2, 32'h0000_0001, 16'h4000, 0);        // across the origin
    draw_line(320, 240, 320, 240, 7, 32'hDEAD_BEEF, 16'h5555, 0);  // wide brush
    send_tick();
    wait_drained(SETTLE);

    // Random phases, each with its own frame size
    phase_w = '{13'd4096, 13'd1, 13'd8191, 13'd0, 13'd640, 13'd0, 13'd640};
    phase_h = '{13'd4096, 13'd1, 13'd4097, 13'd480, 13'd0, 13'd0, 13'd480};
    phase_w[5] = FRAME_W'($urandom_range(1, 4096));
    phase_h[5] = FRAME_W'($urandom_range(1, 4096));
    for (int p = 0; p < 7; p++) begin
      write_reg(REG_FRAME_WIDTH, phase_w[p]);
      write_reg(REG_FRAME_HEIGHT, phase_h[p]);
      items_sent = 0;
      while (items_sent < PHASE_ITEMS) random_line();
      wait_drained(SETTLE);
    end

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
